FILE: hdl/mbfr_pkg.sv
// Shared constants and types for the MSB-first bit field reader.
package mbfr_pkg;

    localparam int STORE_BYTES_DEF    = 4096;
    localparam int MAX_FIELD_BITS_DEF = 64;
    localparam int WORD_BITS          = 64;

    typedef logic [1:0] t_opcode;
    typedef logic [1:0] t_status;

    localparam t_opcode OP_LOAD = 2'd0;
    localparam t_opcode OP_SEEK = 2'd1;
    localparam t_opcode OP_READ = 2'd2;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_WIDTH      = 2'd1;
    localparam t_status ST_PAST_END   = 2'd2;
    localparam t_status ST_SEEK_RANGE = 2'd3;

endpackage

FILE: hdl/mbfr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mbfr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/msb_first_bit_field_reader_core.sv
// Top level of the MSB-first bit field reader: sequencer, position and result register.
//
// Input items arrive on i_in_valid / o_in_stall and carry an opcode: load byte,
// seek or read field. Each item yields exactly one result on o_out_valid /
// i_out_stall. The byte store lives in a RAM of 64-bit words, eight bytes per
// word with the first byte in the top bits, so a field of up to 64 bits spans
// at most two words.
// A seek, an unused opcode, an ignored load or any read error is answered in
// the accept cycle: the result register is written then, valid in the next
// cycle. A load reads the word, then merges the byte and writes it back in S_LD.
// A read fetches two consecutive words over the single RAM read port in S_RD1
// and S_RD2 and extracts the field. The valid bit count register is written
// through i_cfg_we / i_cfg_wdata; the user writes it only while the block is
// idle, which the block does not enforce. Reset clears the position, the
// register and the result valid flag; the store is undefined until loaded and
// needs no clearing pass. When the receiver stalls, the result is held and a
// finishing item waits with its RAM address held, so nothing is lost or repeated.
module msb_first_bit_field_reader_core #(
    parameter int STORE_BYTES    = mbfr_pkg::STORE_BYTES_DEF,
    parameter int MAX_FIELD_BITS = mbfr_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [1:0]   i_opcode,
    input  logic [11:0]  i_byte_address,
    input  logic [7:0]   i_byte_value,
    input  logic [14:0]  i_seek_position,
    input  logic [6:0]   i_field_width,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic [63:0]  o_field_value,
    output logic [1:0]   o_status,
    output logic [15:0]  o_position_after
);

    localparam int WORDS = (STORE_BYTES + 7) / 8;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WB    = mbfr_pkg::WORD_BITS;

    localparam logic [23:0] CAP_BITS  = 24'(STORE_BYTES * 8);
    localparam logic [20:0] STORE_END = 21'(STORE_BYTES);
    localparam logic [6:0]  MAX_W     = 7'(MAX_FIELD_BITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LD   = 2'd1;
    localparam logic [1:0] S_RD1  = 2'd2;
    localparam logic [1:0] S_RD2  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_vbc;
    logic        r_out_valid;
    logic [63:0] r_value;
    mbfr_pkg::t_status r_status;
    logic [15:0] r_pos_after;

    logic [AW-1:0] r_word;
    logic [2:0]    r_lane;
    logic [7:0]    r_byte;
    logic [7:0]    r_sh;
    logic [6:0]    r_width;
    logic [WB-1:0] r_w0;

    logic          out_free;
    logic          in_acc;
    logic [15:0]   limit;
    logic [16:0]   end_sum;
    logic          width_err;
    logic          past_err;
    logic          seek_err;
    logic          is_load;
    logic          is_read_ok;
    logic          imm_fire;
    logic          ld_fire;
    logic          rd_fire;
    mbfr_pkg::t_status imm_status;

    logic [AW-1:0]   ram_raddr;
    logic [WB-1:0]   ram_rdata;
    logic [WB-1:0]   merged;
    logic [2*WB-1:0] cat_shift;
    logic [63:0]     mask;
    logic [63:0]     extract;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign limit     = ({8'b0, r_vbc} < CAP_BITS) ? r_vbc : CAP_BITS[15:0];
    assign end_sum   = {1'b0, r_pos} + 17'(i_field_width);
    assign width_err = i_field_width > MAX_W;
    assign past_err  = end_sum > {1'b0, limit};
    assign seek_err  = {1'b0, i_seek_position} >= limit;

    assign is_load    = (i_opcode == mbfr_pkg::OP_LOAD)
                        && ({9'b0, i_byte_address} < STORE_END);
    assign is_read_ok = (i_opcode == mbfr_pkg::OP_READ) && !width_err && !past_err;

    assign imm_fire = in_acc && !is_load && !is_read_ok;
    assign ld_fire  = (r_state == S_LD) && out_free;
    assign rd_fire  = (r_state == S_RD2) && out_free;

    always_comb begin
        imm_status = mbfr_pkg::ST_OK;
        case (i_opcode)
            mbfr_pkg::OP_SEEK: begin
                imm_status = seek_err ? mbfr_pkg::ST_SEEK_RANGE : mbfr_pkg::ST_OK;
            end
            mbfr_pkg::OP_READ: begin
                imm_status = width_err ? mbfr_pkg::ST_WIDTH : mbfr_pkg::ST_PAST_END;
            end
            default: begin
                imm_status = mbfr_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (is_load) begin
                        n_state = S_LD;
                    end else if (is_read_ok) begin
                        n_state = S_RD1;
                        n_pos   = end_sum[15:0];
                    end else if ((i_opcode == mbfr_pkg::OP_SEEK) && !seek_err) begin
                        n_pos = {1'b0, i_seek_position};
                    end
                end
            end
            S_LD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RD1: begin
                n_state = S_RD2;
            end
            S_RD2: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                if (i_opcode == mbfr_pkg::OP_LOAD) begin
                    ram_raddr = AW'(i_byte_address >> 3);
                end else begin
                    ram_raddr = AW'(r_pos >> 6);
                end
            end
            S_LD: begin
                ram_raddr = r_word;
            end
            default: begin
                ram_raddr = r_word + AW'(1);
            end
        endcase
    end

    always_comb begin
        merged = ram_rdata;
        merged[(7 - r_lane) * 8 +: 8] = r_byte;
    end

    assign cat_shift = {r_w0, ram_rdata} >> r_sh;
    assign mask      = (r_width == 7'd0) ? 64'd0 : ({64{1'b1}} >> (7'd64 - r_width));
    assign extract   = cat_shift[63:0] & mask;

    mbfr_ram #(
        .WIDTH (WB),
        .DEPTH (WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ld_fire),
        .i_waddr (r_word),
        .i_wdata (merged),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= 16'd0;
            r_vbc       <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            if (i_cfg_we) begin
                r_vbc <= i_cfg_wdata;
            end
            if (imm_fire || ld_fire || rd_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lane  <= i_byte_address[2:0];
            r_byte  <= i_byte_value;
            r_width <= i_field_width;
            r_sh    <= 8'd128 - {2'b0, r_pos[5:0]} - {1'b0, i_field_width};
            if (i_opcode == mbfr_pkg::OP_LOAD) begin
                r_word <= AW'(i_byte_address >> 3);
            end else begin
                r_word <= AW'(r_pos >> 6);
            end
        end
        if (r_state == S_RD1) begin
            r_w0 <= ram_rdata;
        end
        if (imm_fire) begin
            r_value     <= 64'd0;
            r_status    <= imm_status;
            r_pos_after <= n_pos;
        end else if (ld_fire) begin
            r_value     <= 64'd0;
            r_status    <= mbfr_pkg::ST_OK;
            r_pos_after <= r_pos;
        end else if (rd_fire) begin
            r_value     <= extract;
            r_status    <= mbfr_pkg::ST_OK;
            r_pos_after <= r_pos;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_field_value    = r_value;
    assign o_status         = r_status;
    assign o_position_after = r_pos_after;

`ifndef NO_ASSERTIONS
    a_pos_moves_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_pos != $past(r_pos))) |-> $past(in_acc))
        else $error("Read position changed without an accepted item.");

    a_read_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_read_ok) |=> (r_state == S_RD1) ##1 (r_state == S_RD2))
        else $error("Accepted read did not fetch two words in turn.");

    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != mbfr_pkg::ST_OK)) |-> (o_field_value == 64'd0))
        else $error("Result with an error status carries a non-zero field.");

    a_no_write_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD1) |=> !ld_fire)
        else $error("Store written while a read was in flight.");
`endif

endmodule
